// File: hw/rtl/hbs_pkg.sv
// Shared types and constants of the heightmap bilinear sampler.
`default_nettype none
package hbs_pkg;

    // Command codes on the action field.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SIDE       = 3'd0;
    localparam logic [2:0] REG_EXTENT     = 3'd1;
    localparam logic [2:0] REG_HALF_SCALE = 3'd2;
    localparam logic [2:0] REG_NORM_FLOOR = 3'd3;
    localparam logic [2:0] REG_NORM_CEIL  = 3'd4;
    localparam logic [2:0] REG_GAIN       = 3'd5;
    localparam logic [2:0] REG_LEAST      = 3'd6;
    localparam logic [2:0] REG_EDGE       = 3'd7;

    // Extremes after a restart.
    localparam logic signed [23:0] ELEV_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ELEV_MIN = -24'sh800000;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_RESTART
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [23:0] sample;
        logic signed [31:0] east_west;
        logic signed [31:0] north_south;
        logic signed [31:0] offset;
    } cmd_t;

    // Configuration register file.
    typedef struct packed {
        logic [8:0]  side;
        logic [30:0] extent;
        logic [16:0] half_scale;
        logic [16:0] norm_floor;
        logic [16:0] norm_ceil;
        logic [15:0] gain;
        logic [7:0]  least;
        logic        edge_ofs;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HALF,
        ST_NORM_START,
        ST_NORM_WAIT,
        ST_INDEX,
        ST_SPLIT,
        ST_ROWBASE,
        ST_READ,
        ST_LERP0,
        ST_LERP1,
        ST_LERP2,
        ST_LERP3,
        ST_LERP4,
        ST_SCALE0,
        ST_SCALE1
    } core_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/hbs_cmd_queue.sv
// Front end: accepts commands, drops unknown codes and queues the rest.
`default_nettype none
module hbs_cmd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         action,
    input  wire logic signed [23:0] elevation_sample,
    input  wire logic signed [31:0] east_west,
    input  wire logic signed [31:0] north_south,
    input  wire logic signed [31:0] height_offset,
    output logic                    busy,
    output logic                    q_valid,
    output hbs_pkg::cmd_t           q_entry,
    input  wire logic               q_pop
);

    hbs_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          push;
    hbs_pkg::cmd_t new_entry;

    // Classify the incoming command.
    always_comb
    begin
        new_entry.sample      = elevation_sample;
        new_entry.east_west   = east_west;
        new_entry.north_south = north_south;
        new_entry.offset      = height_offset;
        new_entry.kind        = hbs_pkg::CMD_LOAD;
        push                  = 1'b0;
        unique case (action)
            hbs_pkg::ACT_LOAD:
            begin
                new_entry.kind = hbs_pkg::CMD_LOAD;
                push           = start && !busy;
            end
            hbs_pkg::ACT_QUERY:
            begin
                new_entry.kind = hbs_pkg::CMD_QUERY;
                push           = start && !busy;
            end
            hbs_pkg::ACT_RESTART:
            begin
                new_entry.kind = hbs_pkg::CMD_RESTART;
                push           = start && !busy;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign busy    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_entry = entry_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/hbs_norm_div.sv
// Restoring divider that maps a world coordinate to a clamped Q1.16 value.
`default_nettype none
module hbs_norm_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] num,
    input  wire logic [30:0]        den,
    input  wire logic [16:0]        norm_floor,
    input  wire logic [16:0]        norm_ceil,
    output logic                    done,
    output logic [16:0]             value
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [16:0] quo_reg;
    logic        neg_reg;
    logic        big_reg;
    logic        done_reg;
    logic [16:0] value_reg;
    logic [31:0] trial;
    logic        ge;
    logic [16:0] quo_next;
    logic        start_big;

    // One quotient bit per cycle; the first step compares without a shift.
    always_comb
    begin
        trial     = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[30:0], 1'b0};
        ge        = (trial >= {1'b0, den});
        quo_next  = {quo_reg[15:0], ge};
        start_big = !num[33] && (num[32:0] >= {1'b0, den, 1'b0});
    end

    assign done  = done_reg;
    assign value = value_reg;

    // Iteration datapath and final clamp.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[31:0];
            quo_reg <= 17'd0;
            neg_reg <= num[33];
            big_reg <= start_big;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den}) : trial;
            quo_reg <= quo_next;
            if (cnt_reg == 5'd16)
            begin
                if (neg_reg || (!big_reg && (quo_next < norm_floor)))
                begin
                    value_reg <= norm_floor;
                end
                else if (!big_reg && (quo_next < norm_ceil))
                begin
                    value_reg <= quo_next;
                end
                else
                begin
                    value_reg <= norm_ceil;
                end
            end
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 5'd16);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/hbs_core.sv
// Back end: grid store, loading, and the bilinear query sequencer.
`default_nettype none
module hbs_core #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire hbs_pkg::cmd_t      q_entry,
    output logic                    q_pop,
    input  wire hbs_pkg::cfg_t      cfg,
    output logic                    done,
    output logic signed [47:0]      terrain_z,
    output logic                    grid_loaded,
    output logic signed [23:0]      lowest_elevation,
    output logic signed [23:0]      highest_elevation
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int TW    = (CW > 18) ? CW : 18;
    localparam logic [31:0] MAX_SIDE_U = MAX_SIDE;
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    // Clamp an index to side - 1.
    function automatic logic [SW-1:0] lim_idx(input logic [SW-1:0] i,
                                              input logic [SW-1:0] lim);
        lim_idx = (i > lim) ? lim : i;
    endfunction

    // a + floor(prod / 2^16).
    function automatic logic signed [23:0] lerp_sum(input logic signed [23:0] a,
                                                    input logic signed [41:0] p);
        logic signed [25:0] s;
        s        = 26'(a) + p[41:16];
        lerp_sum = s[23:0];
    endfunction

    hbs_pkg::core_state_t state_reg, state_next;

    logic signed [23:0] store_mem [DEPTH];
    logic signed [23:0] mem_rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [AW-1:0]      rd_addr;

    logic [CW-1:0]      count_reg;
    logic signed [23:0] min_reg;
    logic signed [23:0] max_reg;

    logic signed [31:0] ew_reg, ns_reg, off_reg;
    logic [31:0]        half_reg;
    logic [SW-1:0]      term_reg;
    logic [16+SW:0]     colq_reg, rowq_reg;
    logic [SW-1:0]      c0_reg, c1_reg, r0_reg, r1_reg;
    logic [15:0]        tx_reg, ty_reg;
    logic [2*SW-1:0]    rb0_reg, rb1_reg;
    logic [2:0]         rd_cnt_reg;
    logic signed [23:0] cell_reg [4];
    logic signed [41:0] prod_reg;
    logic signed [23:0] top_reg, bot_reg, h_reg;

    logic               done_reg, loaded_reg;
    logic signed [47:0] z_reg;
    logic signed [23:0] lo_reg, hi_reg;

    logic [TW-1:0]      total;
    logic               can_load;
    logic               loaded;
    logic [SW-1:0]      side_w;
    logic [30:0]        den_eff;
    logic signed [33:0] num_x, num_y;
    logic               div_start;
    logic               div_x_done, div_y_done;
    logic [16:0]        nx, ny;
    logic [47:0]        half_prod;
    logic [SW-1:0]      c0_raw, r0_raw;
    logic [SW:0]        c1_raw, r1_raw;
    logic [SW-1:0]      c1_lim, r1_lim, side_lim;
    logic [2*SW-1:0]    rd_sum;
    logic signed [33:0] z_sum;

    // Grid status and derived quantities.
    always_comb
    begin
        side_w    = SW'(cfg.side);
        side_lim  = side_w - SW'(1);
        total     = TW'(cfg.side) * TW'(cfg.side);
        can_load  = (TW'(count_reg) < total) && (count_reg < DEPTH_C);
        loaded    = (cfg.side > {1'b0, cfg.least}) && (32'(cfg.side) <= MAX_SIDE_U)
                    && (TW'(count_reg) == total);
        den_eff   = (cfg.extent == 31'd0) ? 31'd1 : cfg.extent;
        half_prod = 48'(cfg.extent) * 48'(cfg.half_scale);
        num_x     = 34'(ew_reg) + $signed({2'b00, half_reg});
        num_y     = $signed({2'b00, half_reg}) - 34'(ns_reg);
        c0_raw    = colq_reg[15+SW:16];
        r0_raw    = rowq_reg[15+SW:16];
        c1_raw    = (SW+1)'(c0_raw) + (SW+1)'(cfg.edge_ofs);
        r1_raw    = (SW+1)'(r0_raw) + (SW+1)'(cfg.edge_ofs);
        c1_lim    = (c1_raw > (SW+1)'(term_reg)) ? term_reg : c1_raw[SW-1:0];
        r1_lim    = (r1_raw > (SW+1)'(term_reg)) ? term_reg : r1_raw[SW-1:0];
        z_sum     = 34'(prod_reg >>> 12) + 34'(off_reg);
    end

    // Neighbor read address for each read step.
    always_comb
    begin
        case (rd_cnt_reg)
            3'd0:    rd_sum = rb0_reg + (2*SW)'(c0_reg);
            3'd1:    rd_sum = rb0_reg + (2*SW)'(c1_reg);
            3'd2:    rd_sum = rb1_reg + (2*SW)'(c0_reg);
            default: rd_sum = rb1_reg + (2*SW)'(c1_reg);
        endcase
        rd_addr = rd_sum[AW-1:0];
    end

    // Next state and control outputs.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        mem_addr   = rd_addr;
        unique case (state_reg)
            hbs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.kind == hbs_pkg::CMD_LOAD && can_load)
                    begin
                        mem_we   = 1'b1;
                        mem_addr = count_reg[AW-1:0];
                    end
                    if (q_entry.kind == hbs_pkg::CMD_QUERY && loaded)
                    begin
                        state_next = hbs_pkg::ST_HALF;
                    end
                end
            end
            hbs_pkg::ST_HALF:       state_next = hbs_pkg::ST_NORM_START;
            hbs_pkg::ST_NORM_START:
            begin
                div_start  = 1'b1;
                state_next = hbs_pkg::ST_NORM_WAIT;
            end
            hbs_pkg::ST_NORM_WAIT:
            begin
                if (div_x_done && div_y_done)
                begin
                    state_next = hbs_pkg::ST_INDEX;
                end
            end
            hbs_pkg::ST_INDEX:      state_next = hbs_pkg::ST_SPLIT;
            hbs_pkg::ST_SPLIT:      state_next = hbs_pkg::ST_ROWBASE;
            hbs_pkg::ST_ROWBASE:    state_next = hbs_pkg::ST_READ;
            hbs_pkg::ST_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = hbs_pkg::ST_LERP0;
                end
            end
            hbs_pkg::ST_LERP0:      state_next = hbs_pkg::ST_LERP1;
            hbs_pkg::ST_LERP1:      state_next = hbs_pkg::ST_LERP2;
            hbs_pkg::ST_LERP2:      state_next = hbs_pkg::ST_LERP3;
            hbs_pkg::ST_LERP3:      state_next = hbs_pkg::ST_LERP4;
            hbs_pkg::ST_LERP4:      state_next = hbs_pkg::ST_SCALE0;
            hbs_pkg::ST_SCALE0:     state_next = hbs_pkg::ST_SCALE1;
            hbs_pkg::ST_SCALE1:     state_next = hbs_pkg::ST_IDLE;
            default:                state_next = hbs_pkg::ST_IDLE;
        endcase
    end

    // Single-port elevation store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= q_entry.sample;
        end
        mem_rdata_reg <= store_mem[mem_addr];
    end

    // Normalizing dividers for the two axes.
    hbs_norm_div u_div_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .num        (num_x),
        .den        (den_eff),
        .norm_floor (cfg.norm_floor),
        .norm_ceil  (cfg.norm_ceil),
        .done       (div_x_done),
        .value      (nx)
    );

    hbs_norm_div u_div_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .num        (num_y),
        .den        (den_eff),
        .norm_floor (cfg.norm_floor),
        .norm_ceil  (cfg.norm_ceil),
        .done       (div_y_done),
        .value      (ny)
    );

    // Query datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hbs_pkg::ST_IDLE:
            begin
                ew_reg  <= q_entry.east_west;
                ns_reg  <= q_entry.north_south;
                off_reg <= q_entry.offset;
                z_reg   <= 48'sd0;
                lo_reg  <= min_reg;
                hi_reg  <= max_reg;
            end
            hbs_pkg::ST_HALF:
            begin
                half_reg <= half_prod[47:16];
                term_reg <= side_w - SW'(cfg.edge_ofs);
            end
            hbs_pkg::ST_INDEX:
            begin
                colq_reg <= (17+SW)'(nx) * (17+SW)'(term_reg);
                rowq_reg <= (17+SW)'(ny) * (17+SW)'(term_reg);
            end
            hbs_pkg::ST_SPLIT:
            begin
                c0_reg <= lim_idx(c0_raw, side_lim);
                r0_reg <= lim_idx(r0_raw, side_lim);
                c1_reg <= lim_idx(c1_lim, side_lim);
                r1_reg <= lim_idx(r1_lim, side_lim);
                tx_reg <= colq_reg[15:0];
                ty_reg <= rowq_reg[15:0];
            end
            hbs_pkg::ST_ROWBASE:
            begin
                rb0_reg <= (2*SW)'(r0_reg) * (2*SW)'(side_w);
                rb1_reg <= (2*SW)'(r1_reg) * (2*SW)'(side_w);
            end
            hbs_pkg::ST_READ:
            begin
                if (rd_cnt_reg != 3'd0)
                begin
                    cell_reg[rd_cnt_reg[1:0] - 2'd1] <= mem_rdata_reg;
                end
            end
            hbs_pkg::ST_LERP0:
            begin
                prod_reg <= 42'(25'(cell_reg[1]) - 25'(cell_reg[0]))
                            * 42'($signed({1'b0, tx_reg}));
            end
            hbs_pkg::ST_LERP1:
            begin
                top_reg  <= lerp_sum(cell_reg[0], prod_reg);
                prod_reg <= 42'(25'(cell_reg[3]) - 25'(cell_reg[2]))
                            * 42'($signed({1'b0, tx_reg}));
            end
            hbs_pkg::ST_LERP2:
            begin
                bot_reg <= lerp_sum(cell_reg[2], prod_reg);
            end
            hbs_pkg::ST_LERP3:
            begin
                prod_reg <= 42'(25'(bot_reg) - 25'(top_reg))
                            * 42'($signed({1'b0, ty_reg}));
            end
            hbs_pkg::ST_LERP4:
            begin
                h_reg <= lerp_sum(top_reg, prod_reg);
            end
            hbs_pkg::ST_SCALE0:
            begin
                prod_reg <= 42'(25'(h_reg) - 25'(min_reg))
                            * 42'($signed({1'b0, cfg.gain}));
            end
            hbs_pkg::ST_SCALE1:
            begin
                z_reg <= 48'(z_sum);
            end
            default:
            begin
            end
        endcase
    end

    // Control state, grid fill and extremes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hbs_pkg::ST_IDLE;
            count_reg  <= '0;
            min_reg    <= hbs_pkg::ELEV_MAX;
            max_reg    <= hbs_pkg::ELEV_MIN;
            rd_cnt_reg <= 3'd0;
            done_reg   <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A result follows an unloaded query at once, or the last scale step.
            done_reg  <= ((state_reg == hbs_pkg::ST_IDLE) && q_valid
                          && (q_entry.kind == hbs_pkg::CMD_QUERY) && !loaded)
                         || (state_reg == hbs_pkg::ST_SCALE1);
            if (state_reg == hbs_pkg::ST_IDLE && q_valid)
            begin
                unique case (q_entry.kind)
                    hbs_pkg::CMD_LOAD:
                    begin
                        if (can_load)
                        begin
                            count_reg <= count_reg + CW'(1);
                            if (q_entry.sample < min_reg)
                            begin
                                min_reg <= q_entry.sample;
                            end
                            if (q_entry.sample > max_reg)
                            begin
                                max_reg <= q_entry.sample;
                            end
                        end
                    end
                    hbs_pkg::CMD_RESTART:
                    begin
                        count_reg <= '0;
                        min_reg   <= hbs_pkg::ELEV_MAX;
                        max_reg   <= hbs_pkg::ELEV_MIN;
                    end
                    hbs_pkg::CMD_QUERY:
                    begin
                        loaded_reg <= loaded;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == hbs_pkg::ST_ROWBASE)
            begin
                rd_cnt_reg <= 3'd0;
            end
            else if (state_reg == hbs_pkg::ST_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
        end
    end

    assign done              = done_reg;
    assign terrain_z         = z_reg;
    assign grid_loaded       = loaded_reg;
    assign lowest_elevation  = lo_reg;
    assign highest_elevation = hi_reg;

endmodule
`default_nettype wire

// File: hw/rtl/heightmap_bilinear_sampler_unit.sv
// Top level: configuration registers, command queue and sampling core.
// Loads and restarts are handled in the core's idle state; a query on an unloaded
// grid reports without leaving the idle state, while a loaded query runs the 17-step
// normalizing divider and the four reads of the single-port store.
// Commands are taken while the core works until the two-entry queue fills.
// Reset clears the count, the extremes and all control state; the store is
// left as it is. Results appear for one cycle on done and cannot be stalled.
`default_nettype none
module heightmap_bilinear_sampler_unit #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic signed [23:0] elevation_sample,
    input  wire logic signed [31:0] east_west,
    input  wire logic signed [31:0] north_south,
    input  wire logic signed [31:0] height_offset,
    output logic                    done,
    output logic signed [47:0]      terrain_z,
    output logic                    grid_loaded,
    output logic signed [23:0]      lowest_elevation,
    output logic signed [23:0]      highest_elevation,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    hbs_pkg::cfg_t cfg_reg;
    logic          q_valid;
    logic          q_pop;
    hbs_pkg::cmd_t q_entry;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side       <= 9'd0;
            cfg_reg.extent     <= 31'd16;
            cfg_reg.half_scale <= 17'd32768;
            cfg_reg.norm_floor <= 17'd0;
            cfg_reg.norm_ceil  <= 17'd65536;
            cfg_reg.gain       <= 16'd256;
            cfg_reg.least      <= 8'd1;
            cfg_reg.edge_ofs   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hbs_pkg::REG_SIDE:       cfg_reg.side       <= cfg_data[8:0];
                hbs_pkg::REG_EXTENT:     cfg_reg.extent     <= cfg_data[30:0];
                hbs_pkg::REG_HALF_SCALE: cfg_reg.half_scale <= cfg_data[16:0];
                hbs_pkg::REG_NORM_FLOOR: cfg_reg.norm_floor <= cfg_data[16:0];
                hbs_pkg::REG_NORM_CEIL:  cfg_reg.norm_ceil  <= cfg_data[16:0];
                hbs_pkg::REG_GAIN:       cfg_reg.gain       <= cfg_data[15:0];
                hbs_pkg::REG_LEAST:      cfg_reg.least      <= cfg_data[7:0];
                hbs_pkg::REG_EDGE:       cfg_reg.edge_ofs   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end.
    hbs_cmd_queue u_queue (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .action           (action),
        .elevation_sample (elevation_sample),
        .east_west        (east_west),
        .north_south      (north_south),
        .height_offset    (height_offset),
        .busy             (busy),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop)
    );

    // Back end.
    hbs_core #(
        .MAX_SIDE (MAX_SIDE)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_entry           (q_entry),
        .q_pop             (q_pop),
        .cfg               (cfg_reg),
        .done              (done),
        .terrain_z         (terrain_z),
        .grid_loaded       (grid_loaded),
        .lowest_elevation  (lowest_elevation),
        .highest_elevation (highest_elevation)
    );

endmodule
`default_nettype wire

// File: hw/rtl/hbs_checker.sv
// Port-level checks of the sampler, bound to the top level.
`default_nettype none
module hbs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [47:0] terrain_z,
    input wire logic               grid_loaded,
    input wire logic signed [23:0] lowest_elevation,
    input wire logic signed [23:0] highest_elevation,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready
);

    // An unloaded grid always reports zero height.
    a_unloaded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !grid_loaded |-> terrain_z == 48'sd0)
        else $error("unloaded query reported nonzero height");

    // A loaded grid holds at least one sample, so the extremes are ordered.
    a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && grid_loaded |-> lowest_elevation <= highest_elevation)
        else $error("loaded query with minimum above maximum");

    // The configuration port never stalls a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // The queue is empty and no result can appear in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done && !busy)
        else $error("result or busy right after reset");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .busy              (busy),
    .done              (done),
    .terrain_z         (terrain_z),
    .grid_loaded       (grid_loaded),
    .lowest_elevation  (lowest_elevation),
    .highest_elevation (highest_elevation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready)
);
`default_nettype wire
